// ----- design/rws_pkg.sv -----
// Package: shared types and codes for the roulette wheel selector.
`timescale 1ns / 1ps

package rws_pkg;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SELECT = 1'b1;

    typedef struct packed {
        logic        func;
        logic [4:0]  member;
        logic [7:0]  fitness;
        logic [15:0] random_draw;
    } t_in_word;

    typedef struct packed {
        logic [4:0] chosen_member;
        logic       found;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WR_UPD,
        ST_MUL,
        ST_WALK,
        ST_DONE
    } t_state;

endpackage

// ----- design/rws_ram.sv -----
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module rws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/roulette_wheel_select.sv -----
// Top level: fitness-proportionate (roulette wheel) selector.
`timescale 1ns / 1ps

// Fitness values live in a MEMBERS-deep RAM with a registered read;
// a running total sits in a register. A write word (func 0) first reads
// the old fitness, then writes the new one and adjusts the total. A
// select word (func 1) returns the first member whose cumulative fitness
// c satisfies r * total < c * 2^RANDOM_BITS. It first forms r * total,
// then walks the RAM one member per cycle; with a zero total it answers
// found = 0 without the walk. Writes to members at or above MEMBERS are
// dropped. After reset a clearing pass writes zero to every entry, during
// which no word is accepted. A finished result waits in an output
// register, so the next word may be accepted while it is still pending.
module roulette_wheel_select #(
    parameter int MEMBERS      = 32,
    parameter int FITNESS_BITS = 8,
    parameter int RANDOM_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  rws_pkg::t_in_word     i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output rws_pkg::t_out_word    o_data
);

    localparam int IDX_W   = $clog2(MEMBERS);
    localparam int TOTAL_W = FITNESS_BITS + $clog2(MEMBERS);
    localparam int PROD_W  = RANDOM_BITS + TOTAL_W;

    rws_pkg::t_state    r_state, n_state;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [TOTAL_W-1:0] r_total, n_total;
    logic               r_out_valid, n_out_valid;

    logic [TOTAL_W-1:0]      r_cum, n_cum;
    logic [PROD_W-1:0]       r_prod, n_prod;
    logic [RANDOM_BITS-1:0]  r_rand, n_rand;
    logic [IDX_W-1:0]        r_wr_addr, n_wr_addr;
    logic [FITNESS_BITS-1:0] r_wr_data, n_wr_data;
    rws_pkg::t_out_word      r_res, n_res;
    rws_pkg::t_out_word      r_out, n_out;

    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [FITNESS_BITS-1:0] ram_wdata;
    logic [IDX_W-1:0]        ram_raddr;
    logic [FITNESS_BITS-1:0] ram_rdata;

    logic [31:0]             in_member_ext;
    logic [31:0]             in_fit_ext;
    logic [31:0]             in_rand_ext;
    logic [31:0]             idx_ext;
    logic                    in_member_ok;
    logic                    idx_last;
    logic                    out_free;
    logic [TOTAL_W-1:0]      cum_now;

    assign in_member_ext = 32'(i_data.member);
    assign in_fit_ext    = 32'(i_data.fitness);
    assign in_rand_ext   = 32'(i_data.random_draw);
    assign idx_ext       = 32'(r_idx);
    assign in_member_ok  = int'(i_data.member) < MEMBERS;
    assign idx_last      = (r_idx == IDX_W'(MEMBERS - 1));
    assign out_free      = !r_out_valid || i_ready;
    assign cum_now       = r_cum + TOTAL_W'(ram_rdata);

    rws_ram #(
        .WIDTH(FITNESS_BITS),
        .DEPTH(MEMBERS)
    ) u_fit_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_total     = r_total;
        n_out_valid = r_out_valid;
        n_cum       = r_cum;
        n_prod      = r_prod;
        n_rand      = r_rand;
        n_wr_addr   = r_wr_addr;
        n_wr_data   = r_wr_data;
        n_res       = r_res;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_waddr   = r_wr_addr;
        ram_wdata   = r_wr_data;
        ram_raddr   = '0;
        o_ready     = 1'b0;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            rws_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_wdata = '0;
                n_idx     = r_idx + 1'b1;
                if (idx_last) begin
                    n_idx   = '0;
                    n_state = rws_pkg::ST_IDLE;
                end
            end
            rws_pkg::ST_IDLE: begin
                o_ready   = 1'b1;
                n_wr_addr = in_member_ext[IDX_W-1:0];
                n_wr_data = in_fit_ext[FITNESS_BITS-1:0];
                n_rand    = in_rand_ext[RANDOM_BITS-1:0];
                ram_raddr = in_member_ext[IDX_W-1:0];
                if (i_valid) begin
                    if (i_data.func == rws_pkg::FUNC_WRITE) begin
                        if (in_member_ok) begin
                            n_state = rws_pkg::ST_WR_UPD;
                        end
                    end else if (r_total == '0) begin
                        n_res   = '{chosen_member: '0, found: 1'b0};
                        n_state = rws_pkg::ST_DONE;
                    end else begin
                        n_state = rws_pkg::ST_MUL;
                    end
                end
            end
            rws_pkg::ST_WR_UPD: begin
                // read data holds the old fitness of this member
                ram_we    = 1'b1;
                n_total   = r_total - TOTAL_W'(ram_rdata) + TOTAL_W'(r_wr_data);
                n_state   = rws_pkg::ST_IDLE;
            end
            rws_pkg::ST_MUL: begin
                n_prod    = PROD_W'(r_rand) * PROD_W'(r_total);
                n_cum     = '0;
                n_idx     = '0;
                ram_raddr = '0;
                n_state   = rws_pkg::ST_WALK;
            end
            rws_pkg::ST_WALK: begin
                ram_raddr = idx_last ? '0 : r_idx + 1'b1;
                n_cum     = cum_now;
                n_idx     = r_idx + 1'b1;
                if (r_prod < {cum_now, {RANDOM_BITS{1'b0}}}) begin
                    n_res   = '{chosen_member: idx_ext[4:0], found: 1'b1};
                    n_state = rws_pkg::ST_DONE;
                end else if (idx_last) begin
                    n_res   = '{chosen_member: '0, found: 1'b0};
                    n_state = rws_pkg::ST_DONE;
                end
            end
            rws_pkg::ST_DONE: begin
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = rws_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rws_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rws_pkg::ST_CLEAR;
            r_idx       <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cum     <= n_cum;
        r_prod    <= n_prod;
        r_rand    <= n_rand;
        r_wr_addr <= n_wr_addr;
        r_wr_data <= n_wr_data;
        r_res     <= n_res;
        r_out     <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule
